@@ rtl/ipv4hb_pkg.sv @@
// Shared types and constants for the IPv4 header builder.
`timescale 1ns / 1ps
`default_nettype none
package ipv4hb_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_LOCAL_IP   = 3'd0,
    REG_GATEWAY_IP = 3'd1,
    REG_TTL        = 3'd2,
    REG_HOST0_IP   = 3'd3,
    REG_HOST1_IP   = 3'd4,
    REG_HOST2_IP   = 3'd5,
    REG_HOST3_IP   = 3'd6
  } reg_index_t;

  // Packet kinds
  typedef enum logic [1:0] {
    KIND_UDP  = 2'd0,
    KIND_TCP  = 2'd1,
    KIND_ICMP = 2'd2,
    KIND_DNS  = 2'd3
  } packet_kind_t;

  // Request modes
  localparam logic FUNC_NORMAL = 1'b0;
  localparam logic FUNC_PING   = 1'b1;

  localparam logic [7:0]  VER_IHL      = 8'h45;
  localparam logic [7:0]  TOS          = 8'h00;
  localparam logic [15:0] FLAGS_FRAG   = 16'h0000;
  localparam logic [15:0] IDENT_RESET  = 16'h1200;
  localparam logic [15:0] IDENT_WRAP   = 16'hFFFF;
  localparam logic [7:0]  TTL_RESET    = 8'd64;

  localparam logic [7:0]  PROTO_ICMP   = 8'h01;
  localparam logic [7:0]  PROTO_TCP    = 8'h06;
  localparam logic [7:0]  PROTO_UDP    = 8'h11;

  // Width of the raw sum of the ten header halfwords
  localparam int unsigned SUM_W = 20;

  // Fold a ones' complement sum down to 16 bits (two end-around carries)
  function automatic logic [15:0] ones_fold(input logic [SUM_W-1:0] s);
    logic [16:0] a;
    logic [16:0] b;
    a = 17'(s[15:0]) + 17'(s[SUM_W-1:16]);
    b = 17'(a[15:0]) + 17'(a[16]);
    return b[15:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/ipv4_header_builder_unit.sv @@
// IPv4 header builder: header fields, identification counter and checksum.
// A request is accepted into the input register; the assembled header is then
//   captured in the result register.
// Throughput: one request per cycle; both registers advance together unless
//   the header output is stalled.
// Reset (rst, synchronous, active high): pipeline emptied, identification
//   counter to 0x1200, TTL to 64, all addresses to 0.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_header_builder_unit #(
  parameter int NUM_HOSTS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [1:0]  packet_kind,
  input  wire logic [1:0]  host_index,
  input  wire logic [15:0] total_length,
  input  wire logic [15:0] echo_id,
  // header channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      header_word0,
  output logic [31:0]      header_word1,
  output logic [31:0]      header_word2,
  output logic [31:0]      header_word3,
  output logic [31:0]      header_word4,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int HIDX_W = (NUM_HOSTS > 1) ? $clog2(NUM_HOSTS) : 1;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [31:0] local_ip;
  logic [31:0] gateway_ip;
  logic [7:0]  ttl;
  logic [31:0] host_ip [NUM_HOSTS];

  logic cfg_we;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip   <= '0;
      gateway_ip <= '0;
      ttl        <= ipv4hb_pkg::TTL_RESET;
      for (int i = 0; i < NUM_HOSTS; i++) begin
        host_ip[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == ipv4hb_pkg::REG_LOCAL_IP)   local_ip   <= cfg_data;
      if (cfg_index == ipv4hb_pkg::REG_GATEWAY_IP) gateway_ip <= cfg_data;
      if (cfg_index == ipv4hb_pkg::REG_TTL)        ttl        <= cfg_data[7:0];
      // host table entries sit at consecutive indexes; those past the table are dropped
      for (int i = 0; i < NUM_HOSTS; i++) begin
        if (cfg_index == 3'(int'(ipv4hb_pkg::REG_HOST0_IP) + i)) host_ip[i] <= cfg_data;
      end
    end
  end

  // ---------------------------------------------------------------
  // Pipeline control: each stage moves on when the one after it is free
  // ---------------------------------------------------------------
  logic s1_valid;
  logic out_hold;
  logic s1_hold;
  logic in_xfer;
  logic s1_move;

  assign out_hold = out_valid && out_stall;
  assign s1_hold  = s1_valid && out_hold;
  assign in_stall = s1_hold;
  assign in_xfer  = in_valid && !in_stall;
  assign s1_move  = s1_valid && !out_hold;

  // ---------------------------------------------------------------
  // Identification counter: advances on every request transfer
  // ---------------------------------------------------------------
  logic [15:0] ident_counter;
  logic [15:0] ident_inc;
  logic [15:0] ident_counter_next;

  always_comb begin
    ident_inc          = ident_counter + 16'd1;
    ident_counter_next = (ident_inc == ipv4hb_pkg::IDENT_WRAP) ?
                         ipv4hb_pkg::IDENT_RESET : ident_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ident_counter <= ipv4hb_pkg::IDENT_RESET;
    end else if (in_xfer) begin
      ident_counter <= ident_counter_next;
    end
  end

  // ---------------------------------------------------------------
  // Input register: decoded request
  // ---------------------------------------------------------------
  logic [7:0]        s1_proto;
  logic              s1_use_gw;
  logic [HIDX_W-1:0] s1_hidx;
  logic [15:0]       s1_len;
  logic [15:0]       s1_ident;

  logic [7:0]        proto_d;
  logic              use_gw_d;
  logic [HIDX_W-1:0] hidx_d;

  always_comb begin
    // ping reply forces ICMP, which also rules out the gateway
    if (func == ipv4hb_pkg::FUNC_PING) begin
      proto_d  = ipv4hb_pkg::PROTO_ICMP;
      use_gw_d = 1'b0;
    end else begin
      case (packet_kind)
        ipv4hb_pkg::KIND_TCP:  proto_d = ipv4hb_pkg::PROTO_TCP;
        ipv4hb_pkg::KIND_ICMP: proto_d = ipv4hb_pkg::PROTO_ICMP;
        default:               proto_d = ipv4hb_pkg::PROTO_UDP;
      endcase
      use_gw_d = (packet_kind == ipv4hb_pkg::KIND_DNS);
    end
    // host index saturates at the last table entry
    if ({1'b0, host_index} >= 3'(NUM_HOSTS)) begin
      hidx_d = HIDX_W'(NUM_HOSTS - 1);
    end else begin
      hidx_d = HIDX_W'(host_index);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_hold) begin
      s1_valid <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_proto  <= proto_d;
      s1_use_gw <= use_gw_d;
      s1_hidx   <= hidx_d;
      s1_len    <= total_length;
      s1_ident  <= (func == ipv4hb_pkg::FUNC_PING) ? echo_id : ident_counter_next;
    end
  end

  // ---------------------------------------------------------------
  // Header assembly and checksum
  // ---------------------------------------------------------------
  logic [31:0]                 dst;
  logic [ipv4hb_pkg::SUM_W-1:0] sum;
  logic [15:0]                 csum;

  always_comb begin
    dst  = s1_use_gw ? gateway_ip : host_ip[s1_hidx];
    sum  = ipv4hb_pkg::SUM_W'({ipv4hb_pkg::VER_IHL, ipv4hb_pkg::TOS})
         + ipv4hb_pkg::SUM_W'(s1_len)
         + ipv4hb_pkg::SUM_W'(s1_ident)
         + ipv4hb_pkg::SUM_W'(ipv4hb_pkg::FLAGS_FRAG)
         + ipv4hb_pkg::SUM_W'({ttl, s1_proto})
         + ipv4hb_pkg::SUM_W'(local_ip[31:16])
         + ipv4hb_pkg::SUM_W'(local_ip[15:0])
         + ipv4hb_pkg::SUM_W'(dst[31:16])
         + ipv4hb_pkg::SUM_W'(dst[15:0]);
    csum = ~ipv4hb_pkg::ones_fold(sum);
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_hold) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      header_word0 <= {ipv4hb_pkg::VER_IHL, ipv4hb_pkg::TOS, s1_len};
      header_word1 <= {s1_ident, ipv4hb_pkg::FLAGS_FRAG};
      header_word2 <= {ttl, s1_proto, csum};
      header_word3 <= local_ip;
      header_word4 <= dst;
    end
  end

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  // Verifying sum over the emitted header: must fold to all ones
  logic [ipv4hb_pkg::SUM_W-1:0] out_check;
  assign out_check = ipv4hb_pkg::SUM_W'(header_word0[31:16])
                   + ipv4hb_pkg::SUM_W'(header_word0[15:0])
                   + ipv4hb_pkg::SUM_W'(header_word1[31:16])
                   + ipv4hb_pkg::SUM_W'(header_word1[15:0])
                   + ipv4hb_pkg::SUM_W'(header_word2[31:16])
                   + ipv4hb_pkg::SUM_W'(header_word2[15:0])
                   + ipv4hb_pkg::SUM_W'(header_word3[31:16])
                   + ipv4hb_pkg::SUM_W'(header_word3[15:0])
                   + ipv4hb_pkg::SUM_W'(header_word4[31:16])
                   + ipv4hb_pkg::SUM_W'(header_word4[15:0]);

  a_ident_never_wrap: assert property (@(posedge clk) disable iff (rst)
    ident_counter != ipv4hb_pkg::IDENT_WRAP)
    else $error("identification counter reached wrap value");

  a_xfer_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> s1_valid)
    else $error("accepted request lost before the result register");

  a_normal_ident: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && func == ipv4hb_pkg::FUNC_NORMAL) |=> (s1_ident == ident_counter))
    else $error("normal request did not take the advanced identification");

  a_checksum_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ipv4hb_pkg::ones_fold(out_check) == 16'hFFFF))
    else $error("header checksum does not verify");

endmodule
`default_nettype wire
